// ===== hdl/tcc_pkg.sv =====
// Shared types, codes and helper functions for the text console cursor engine.
// Used by tcc_res_fifo, text_console_cursor and the bench; needs nothing else.
`default_nettype none

package tcc_pkg;

	// Result kinds carried on the master-side tuser.
	typedef enum logic [1:0] {
		KIND_DRAW   = 2'd0,
		KIND_SCROLL = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	// Request types carried on the slave-side tuser.
	localparam logic REQ_CHAR = 1'b0;
	localparam logic REQ_SETPOS = 1'b1;

	// Configuration register indexes.
	localparam logic [7:0] REG_WIDTH = 8'd0;
	localparam logic [7:0] REG_HEIGHT = 8'd1;

	localparam logic [7:0] WIDTH_RESET = 8'd80;
	localparam logic [7:0] HEIGHT_RESET = 8'd25;

	// Control characters.
	localparam logic [7:0] CH_NUL = 8'd0;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_NEWLINE = 8'd10;

	localparam logic [7:0] TAB_STOP = 8'd5;
	// floor(c * 205 / 1024) equals floor(c / 5) for every 8-bit c.
	localparam logic [15:0] TAB_RECIP = 16'd205;
	localparam int TAB_SHIFT = 10;

	// Result queue geometry.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	typedef logic [FIFO_AW-1:0] ptr_t;
	typedef logic [FIFO_CW-1:0] cnt_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] glyph;
		logic [7:0] row;
		logic [7:0] col;
		logic       accepted;
		logic       last;
	} res_t;

	// Column after a tab: the next multiple of TAB_STOP, in 9 bits so that
	// running past 255 stays visible.
	function automatic logic [8:0] tab_next(input logic [7:0] c);
		logic [15:0] prod;
		logic [7:0]  quot;
		logic [7:0]  rem;
		begin
			prod = 16'(c) * TAB_RECIP;
			quot = 8'(prod >> TAB_SHIFT);
			rem = c - 8'(quot * TAB_STOP);
			tab_next = 9'(c) + 9'(TAB_STOP) - 9'(rem);
		end
	endfunction

endpackage

`default_nettype wire

// ===== hdl/tcc_res_fifo.sv =====
// Small result queue for the text console cursor engine: takes up to two
// results per cycle, hands out one. Depends on tcc_pkg.
`default_nettype none

module tcc_res_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [1:0]    push_n,
	input  wire tcc_pkg::res_t push0,
	input  wire tcc_pkg::res_t push1,
	output logic               room2,
	output logic               out_valid,
	input  wire logic          out_ready,
	output tcc_pkg::res_t      out_data
);

	tcc_pkg::res_t mem_q [tcc_pkg::FIFO_DEPTH];
	tcc_pkg::ptr_t wr_q;
	tcc_pkg::ptr_t rd_q;
	tcc_pkg::cnt_t cnt_q;
	logic          pop;

	assign out_valid = (cnt_q != '0);
	assign out_data = mem_q[rd_q];
	assign pop = out_valid && out_ready;
	// Room for a full two-result request, judged before this cycle's pop.
	assign room2 = (cnt_q <= tcc_pkg::cnt_t'(tcc_pkg::FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= push0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_q + tcc_pkg::ptr_t'(1)] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + tcc_pkg::ptr_t'(push_n);
			if (pop) begin
				rd_q <= rd_q + tcc_pkg::ptr_t'(1);
			end
			cnt_q <= cnt_q + tcc_pkg::cnt_t'(push_n) - tcc_pkg::cnt_t'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= tcc_pkg::cnt_t'(tcc_pkg::FIFO_DEPTH))
		else $error("result queue over capacity");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd2) |-> room2)
		else $error("two results pushed without room");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |=> out_valid)
		else $error("pushed result not visible");
`endif

endmodule

`default_nettype wire

// ===== hdl/text_console_cursor.sv =====
// Top level of the text console cursor engine: cursor state, per-request
// result logic and configuration. Depends on tcc_pkg and tcc_res_fifo.
`default_nettype none

// The engine takes one request per cycle and writes its results into a
// four-entry result queue; with the queue empty, the first result is offered
// on the master side in the cycle after the request is taken. One result leaves
// per cycle while m_axis_tready is high. A byte that scrolls gives two results,
// NUL, tab and newline none, all other requests one; s_axis_tready drops only
// while the queue holds more than two undelivered results. Configuration
// writes are always taken (cfg_ready is tied high) and act from the next cycle.
module text_console_cursor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // char_code, new_col, new_row
	input  wire logic        s_axis_tuser,  // req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // glyph, row, col, accepted, 7 zero bits
	output logic [1:0]       m_axis_tuser,  // kind
	output logic             m_axis_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	logic [7:0] width_q;
	logic [7:0] height_q;
	logic [7:0] col_q;
	logic [7:0] row_q;

	logic       in_fire;
	logic [7:0] char_code;
	logic [7:0] new_col;
	logic [7:0] new_row;

	logic [7:0] row_adv;
	logic       wrap;
	logic [7:0] col_w;
	logic [7:0] row_w;
	logic       scroll;
	logic [7:0] row_d;
	logic [8:0] tab_col;
	logic       tab_wrap;
	logic       pos_ok;

	logic [7:0]    col_n;
	logic [7:0]    row_n;
	logic [1:0]    push_n;
	tcc_pkg::res_t res0;
	tcc_pkg::res_t res1;
	tcc_pkg::res_t out_res;
	logic          room2;

	assign char_code = s_axis_tdata[7:0];
	assign new_col = s_axis_tdata[15:8];
	assign new_row = s_axis_tdata[23:16];
	assign s_axis_tready = room2;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	// The row saturates at the height instead of wrapping.
	assign row_adv = (row_q < height_q) ? row_q + 8'd1 : row_q;

	assign wrap = (col_q >= width_q);
	assign col_w = wrap ? 8'd0 : col_q;
	assign row_w = wrap ? row_adv : row_q;
	assign scroll = (row_w >= height_q);
	assign row_d = scroll ? height_q - 8'd1 : row_w;

	assign tab_col = tcc_pkg::tab_next(col_q);
	assign tab_wrap = (tab_col >= {1'b0, width_q});

	assign pos_ok = (new_col < width_q) && (new_row < height_q);

	always_comb begin
		col_n = col_q;
		row_n = row_q;
		push_n = 2'd0;
		res0 = '0;
		res1 = '0;
		if (s_axis_tuser == tcc_pkg::REQ_SETPOS) begin
			if (pos_ok) begin
				col_n = new_col;
				row_n = new_row;
			end
			push_n = 2'd1;
			res0.kind = tcc_pkg::KIND_STATUS;
			res0.accepted = pos_ok;
			res0.last = 1'b1;
		end else begin
			case (char_code)
				tcc_pkg::CH_NUL: begin
				end
				tcc_pkg::CH_NEWLINE: begin
					col_n = 8'd0;
					row_n = row_adv;
				end
				tcc_pkg::CH_TAB: begin
					if (tab_wrap) begin
						col_n = 8'd0;
						row_n = row_adv;
					end else begin
						col_n = tab_col[7:0];
					end
				end
				default: begin
					col_n = col_w + 8'd1;
					row_n = row_d;
					if (scroll) begin
						push_n = 2'd2;
						res0.kind = tcc_pkg::KIND_SCROLL;
						res1.kind = tcc_pkg::KIND_DRAW;
						res1.glyph = char_code;
						res1.row = row_d;
						res1.col = col_w;
						res1.last = 1'b1;
					end else begin
						push_n = 2'd1;
						res0.kind = tcc_pkg::KIND_DRAW;
						res0.glyph = char_code;
						res0.row = row_d;
						res0.col = col_w;
						res0.last = 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			width_q <= tcc_pkg::WIDTH_RESET;
			height_q <= tcc_pkg::HEIGHT_RESET;
		end else begin
			if (in_fire) begin
				col_q <= col_n;
				row_q <= row_n;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tcc_pkg::REG_WIDTH: width_q <= cfg_data;
					tcc_pkg::REG_HEIGHT: height_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	tcc_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (in_fire ? push_n : 2'd0),
		.push0     (res0),
		.push1     (res1),
		.room2     (room2),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res)
	);

	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last;
	assign m_axis_tdata = {7'd0, out_res.accepted, out_res.col, out_res.row, out_res.glyph};

`ifndef SYNTHESIS
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == tcc_pkg::KIND_STATUS) |-> m_axis_tlast)
		else $error("position status not marked last");

	a_scroll_then_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tuser == tcc_pkg::KIND_SCROLL) |=>
		(m_axis_tvalid && m_axis_tuser == tcc_pkg::KIND_DRAW))
		else $error("scroll not followed by its draw");

	a_draw_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && push_n != 2'd0 && s_axis_tuser == tcc_pkg::REQ_CHAR &&
		 height_q != 8'd0) |-> (row_d < height_q))
		else $error("glyph drawn below the last row");
`endif

endmodule

`default_nettype wire

// ===== bench/text_console_cursor_checker.sv =====
// Checker for the text console cursor engine: watches the request, result and
// configuration channels, predicts every result and compares it with the block.
// Depends on tcc_pkg for the result kinds, register indexes and constants.
`default_nettype none

module text_console_cursor_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // char_code, new_col, new_row
	input  wire logic        s_axis_tuser,  // req_type
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [31:0] m_axis_tdata,  // glyph, row, col, accepted, 7 zero bits
	input  wire logic [1:0]  m_axis_tuser,  // kind
	input  wire logic        m_axis_tlast,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	output int               mismatch_count,
	output int               results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 10;

	logic [7:0]    scr_width;
	logic [7:0]    scr_height;
	logic [7:0]    cur_col;
	logic [7:0]    cur_row;
	tcc_pkg::res_t screen_ops_due[$];
	int            results_seen;

	function automatic tcc_pkg::res_t make_op(tcc_pkg::kind_t k, logic [7:0] g,
			logic [7:0] r, logic [7:0] c, logic acc, logic lst);
		tcc_pkg::res_t op;
		op.kind = k;
		op.glyph = g;
		op.row = r;
		op.col = c;
		op.accepted = acc;
		op.last = lst;
		return op;
	endfunction

	// The row saturates at the screen height rather than wrapping.
	task automatic next_row();
		if (cur_row < scr_height)
			cur_row = cur_row + 8'd1;
	endtask

	task automatic console_step(logic req, logic [7:0] ch, logic [7:0] nc, logic [7:0] nr);
		logic       in_bounds;
		logic [8:0] tab_col;
		if (req == tcc_pkg::REQ_SETPOS) begin
			in_bounds = (nc < scr_width) && (nr < scr_height);
			if (in_bounds) begin
				cur_col = nc;
				cur_row = nr;
			end
			screen_ops_due.push_back(make_op(tcc_pkg::KIND_STATUS, 8'd0, 8'd0, 8'd0,
				in_bounds, 1'b1));
		end else if (ch == tcc_pkg::CH_NUL) begin
			// Nothing happens.
		end else if (ch == tcc_pkg::CH_NEWLINE) begin
			cur_col = 8'd0;
			next_row();
		end else if (ch == tcc_pkg::CH_TAB) begin
			// Nine bits, so that running past column 255 counts as past the width.
			tab_col = {1'b0, cur_col} + {1'b0, tcc_pkg::TAB_STOP}
				- {1'b0, cur_col % tcc_pkg::TAB_STOP};
			if (tab_col >= {1'b0, scr_width}) begin
				cur_col = 8'd0;
				next_row();
			end else begin
				cur_col = tab_col[7:0];
			end
		end else begin
			if (cur_col >= scr_width) begin
				cur_col = 8'd0;
				next_row();
			end
			if (cur_row >= scr_height) begin
				screen_ops_due.push_back(make_op(tcc_pkg::KIND_SCROLL, 8'd0, 8'd0, 8'd0,
					1'b0, 1'b0));
				cur_row = scr_height - 8'd1;
			end
			screen_ops_due.push_back(make_op(tcc_pkg::KIND_DRAW, ch, cur_row, cur_col,
				1'b0, 1'b1));
			cur_col = cur_col + 8'd1;
		end
	endtask

	task automatic check_result();
		tcc_pkg::res_t seen;
		tcc_pkg::res_t want;
		seen.kind = tcc_pkg::kind_t'(m_axis_tuser);
		seen.glyph = m_axis_tdata[7:0];
		seen.row = m_axis_tdata[15:8];
		seen.col = m_axis_tdata[23:16];
		seen.accepted = m_axis_tdata[24];
		seen.last = m_axis_tlast;
		if (screen_ops_due.size() == 0) begin
			if (mismatch_count < REPORT_LIMIT)
				$display("result %0d arrived with none outstanding: kind %0d glyph %0d",
					results_seen, seen.kind, seen.glyph,
					" row %0d col %0d acc %0b last %0b",
					seen.row, seen.col, seen.accepted, seen.last);
			mismatch_count++;
		end else begin
			want = screen_ops_due.pop_front();
			if (seen.kind !== want.kind || seen.glyph !== want.glyph || seen.row !== want.row
					|| seen.col !== want.col || seen.accepted !== want.accepted
					|| seen.last !== want.last || m_axis_tdata[31:25] !== 7'd0) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("result %0d mismatch: expected kind %0d glyph %0d row %0d",
						results_seen, want.kind, want.glyph, want.row,
						" col %0d acc %0b last %0b,", want.col, want.accepted, want.last,
						" got kind %0d glyph %0d row %0d col %0d",
						seen.kind, seen.glyph, seen.row, seen.col,
						" acc %0b last %0b pad %h",
						seen.accepted, seen.last, m_axis_tdata[31:25]);
				mismatch_count++;
			end
		end
		results_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_width = tcc_pkg::WIDTH_RESET;
			scr_height = tcc_pkg::HEIGHT_RESET;
			cur_col = 8'd0;
			cur_row = 8'd0;
			screen_ops_due.delete();
			results_seen = 0;
			mismatch_count = 0;
			results_due = 0;
		end else begin
			// A request taken at the same edge as a register write still sees the old size.
			if (s_axis_tvalid && s_axis_tready)
				console_step(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
					s_axis_tdata[23:16]);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tcc_pkg::REG_WIDTH: scr_width = cfg_data;
					tcc_pkg::REG_HEIGHT: scr_height = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			results_due = screen_ops_due.size();
		end
	end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Top of the text console cursor bench: clock, reset, request and configuration
// stimulus, result back-pressure and the verdict. Depends on tcc_pkg, the block
// text_console_cursor and text_console_cursor_checker.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int DRAIN_CYCLES = 8;
	localparam int SEGMENTS = 9;
	localparam int REQUESTS_PER_SEGMENT = 84;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [7:0]  cfg_data;
	int          mismatch_count;
	int          results_due;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          quiet_cycles;

	// Screen sizes per random segment; the first keeps the reset size.
	logic [7:0] width_plan[SEGMENTS] = '{8'd80, 8'd1, 8'd255, 8'd5, 8'd255, 8'd1, 8'd7,
		8'd12, 8'd3};
	logic [7:0] height_plan[SEGMENTS] = '{8'd25, 8'd1, 8'd255, 8'd3, 8'd1, 8'd255, 8'd4,
		8'd2, 8'd6};

	text_console_cursor dut (.*);

	text_console_cursor_checker cursor_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Ends the run when no channel has moved anything for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the request is taken,
	// with valid still high so that the next request follows without a gap.
	task automatic send_req(logic req, logic [7:0] ch, logic [7:0] nc, logic [7:0] nr);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= {nr, nc, ch};
		forever begin
			@(posedge clk);
			if (s_axis_tready)
				break;
		end
		@(negedge clk);
	endtask

	task automatic send_char(logic [7:0] ch);
		send_req(tcc_pkg::REQ_CHAR, ch, 8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	task automatic send_setpos(logic [7:0] nc, logic [7:0] nr);
		send_req(tcc_pkg::REQ_SETPOS, 8'($urandom_range(255)), nc, nr);
	endtask

	// Drops the request line, waits for every outstanding result and lets any
	// request without a result finish inside the block.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (results_due != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_screen_size(logic [7:0] w, logic [7:0] h);
		cfg_valid <= 1'b1;
		cfg_index <= tcc_pkg::REG_WIDTH;
		cfg_data <= w;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_index <= tcc_pkg::REG_HEIGHT;
		cfg_data <= h;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Coordinates cluster on the edge of the screen, the rest fall on the screen or anywhere in 8 bits.
	function automatic logic [7:0] pick_coord(logic [7:0] lim);
		case ($urandom_range(3))
			0: return lim - 8'd1;
			1: return lim;
			2: return 8'($urandom_range(int'(lim) - 1));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	initial begin
		int pick;
		int sent;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 24'd0;
		s_axis_tuser = tcc_pkg::REQ_CHAR;
		cfg_valid = 1'b0;
		cfg_index = tcc_pkg::REG_WIDTH;
		cfg_data = 8'd0;
		send_idle_pct = 17;
		recv_idle_pct = 76;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part on the reset screen size of 80 by 25.
		send_setpos(8'd0, 8'd0);
		send_char("A");
		send_char(tcc_pkg::CH_TAB);
		send_char(8'd255);
		send_char(tcc_pkg::CH_NEWLINE);
		send_char(tcc_pkg::CH_NUL);
		send_setpos(8'd79, 8'd24);
		send_char("Z");
		// Column at the width: wraps, runs off the bottom and scrolls.
		send_char("z");
		send_setpos(8'd80, 8'd0);
		send_setpos(8'd0, 8'd25);
		send_setpos(8'd255, 8'd255);
		send_setpos(8'd78, 8'd10);
		send_char(tcc_pkg::CH_TAB);
		send_setpos(8'd74, 8'd3);
		send_char(tcc_pkg::CH_TAB);
		send_setpos(8'd0, 8'd24);
		// Two newlines at the bottom: the row saturates one past the last row.
		send_char(tcc_pkg::CH_NEWLINE);
		send_char(tcc_pkg::CH_NEWLINE);
		send_char(8'd1);
		send_char(8'd8);
		send_char(8'd11);
		send_char(8'd127);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			settle();
			if (seg > 0)
				write_screen_size(width_plan[seg], height_plan[seg]);
			if (seg < 3) begin
				send_idle_pct = 17;
				recv_idle_pct = 76;
			end else if (seg < 6) begin
				send_idle_pct = 76;
				recv_idle_pct = 17;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			sent = 0;
			while (sent < REQUESTS_PER_SEGMENT) begin
				pick = $urandom_range(99);
				if (pick < 10)
					send_setpos(pick_coord(width_plan[seg]), pick_coord(height_plan[seg]));
				else if (pick < 20)
					send_char(tcc_pkg::CH_NEWLINE);
				else if (pick < 28)
					send_char(tcc_pkg::CH_TAB);
				else if (pick < 31)
					send_char(tcc_pkg::CH_NUL);
				else
					send_char(8'($urandom_range(255)));
				if (pick < 28 || pick >= 31)
					sent++;
			end
		end

		s_axis_tvalid <= 1'b0;
		while (results_due != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/tcc_pkg.sv
hdl/tcc_res_fifo.sv
hdl/text_console_cursor.sv
bench/text_console_cursor_checker.sv
bench/testbench.sv
